// ===== src/clock_and_countdown_timer_core_macros.svh =====
// Assertion macros shared by the timer core files.
// Each macro names a property that is checked on the rising edge of clk
// and is switched off while arst_n is low.
`ifndef CLOCK_AND_COUNTDOWN_TIMER_CORE_MACROS_SVH
`define CLOCK_AND_COUNTDOWN_TIMER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CCT_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
`define CCT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define CCT_ASSERT_IMPL(name, ante, cons)
`define CCT_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== src/cct_pkg.sv =====
package cct_pkg;

	localparam int NUM_DIGITS = 6;
	localparam int COUNT_W    = 19;
	localparam int DIGIT_W    = 4;
	localparam int WEIGHT_W   = 16;
	localparam int PROD_W     = WEIGHT_W + DIGIT_W;
	localparam int TICK_W     = 8;
	localparam int LOAD_W     = 20;
	localparam int MAX_DIGIT  = 9;

	localparam logic [COUNT_W-1:0] LOAD_MAX = 19'd359999;
	localparam logic [COUNT_W-1:0] DAY_LAST = 19'd86399;
	localparam logic [TICK_W-1:0]  TICKS_RESET = 8'd125;

	localparam logic [WEIGHT_W-1:0] DIGIT_WEIGHT [NUM_DIGITS] = '{
		16'd36000, 16'd3600, 16'd600, 16'd60, 16'd10, 16'd1
	};

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	localparam logic MODE_CLOCK     = 1'b0;
	localparam logic MODE_COUNTDOWN = 1'b1;

	localparam logic CFG_TICKS_PER_SECOND = 1'b0;
	localparam logic CFG_COUNT_MODE       = 1'b1;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		logic [COUNT_W-1:0]           rem;
		digit_t [NUM_DIGITS-1:0]      digits;
		logic                         passed;
		logic                         done;
	} beat_t;

endpackage

// ===== src/cct_cell.sv =====
module cct_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cct_pkg::WEIGHT_W-1:0]  weight,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  cct_pkg::beat_t                up_beat,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output cct_pkg::beat_t                dn_beat
);

	logic                          valid_q;
	cct_pkg::beat_t                beat_q;
	cct_pkg::digit_t               digit;
	logic [cct_pkg::PROD_W-1:0]    product;
	logic [cct_pkg::COUNT_W-1:0]   rem_next;

	always_comb begin
		digit = '0;
		for (int j = 1; j <= cct_pkg::MAX_DIGIT; j++) begin
			if (cct_pkg::PROD_W'(up_beat.rem) >=
			    cct_pkg::PROD_W'(j) * cct_pkg::PROD_W'(weight)) begin
				digit = cct_pkg::DIGIT_W'(j);
			end
		end
		product  = cct_pkg::PROD_W'(digit) * cct_pkg::PROD_W'(weight);
		rem_next = cct_pkg::COUNT_W'(cct_pkg::PROD_W'(up_beat.rem) - product);
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			beat_q.rem    <= rem_next;
			beat_q.digits <= {up_beat.digits[cct_pkg::NUM_DIGITS-2:0], digit};
			beat_q.passed <= up_beat.passed;
			beat_q.done   <= up_beat.done;
		end
	end

	assign dn_valid = valid_q;
	assign dn_beat  = beat_q;

endmodule

// ===== src/cct_front.sv =====
`include "clock_and_countdown_timer_core_macros.svh"

module cct_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [cct_pkg::TICK_W-1:0]    cfg_data,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic                          kind,
	input  logic [cct_pkg::DIGIT_W-1:0]   hour_tens,
	input  logic [cct_pkg::DIGIT_W-1:0]   hour_units,
	input  logic [cct_pkg::DIGIT_W-1:0]   minute_tens,
	input  logic [cct_pkg::DIGIT_W-1:0]   minute_units,
	input  logic [cct_pkg::DIGIT_W-1:0]   second_tens,
	input  logic [cct_pkg::DIGIT_W-1:0]   second_units,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output cct_pkg::beat_t                dn_beat
);

	logic [cct_pkg::TICK_W-1:0]   tps_q;
	logic                         mode_q;
	logic [cct_pkg::TICK_W-1:0]   tick_q;
	logic [cct_pkg::COUNT_W-1:0]  count_q;
	logic                         done_q;
	logic                         valid_s1;
	cct_pkg::beat_t               beat_s1;

	logic                         accept;
	logic [cct_pkg::TICK_W:0]     tick_inc;
	logic                         sec_event;
	logic [cct_pkg::LOAD_W-1:0]   total;
	logic [cct_pkg::COUNT_W-1:0]  load_count;
	logic [cct_pkg::COUNT_W-1:0]  up_count;
	logic [cct_pkg::COUNT_W-1:0]  down_count;
	logic [cct_pkg::TICK_W-1:0]   tick_n;
	logic [cct_pkg::COUNT_W-1:0]  count_n;
	logic                         done_n;
	logic                         passed;

	assign up_ready = !valid_s1 || dn_ready;
	assign accept   = up_valid && up_ready;

	always_comb begin
		tick_inc  = {1'b0, tick_q} + 1'b1;
		sec_event = tick_inc >= {1'b0, tps_q};
		total = cct_pkg::LOAD_W'(hour_tens)    * cct_pkg::LOAD_W'(cct_pkg::DIGIT_WEIGHT[0])
		      + cct_pkg::LOAD_W'(hour_units)   * cct_pkg::LOAD_W'(cct_pkg::DIGIT_WEIGHT[1])
		      + cct_pkg::LOAD_W'(minute_tens)  * cct_pkg::LOAD_W'(cct_pkg::DIGIT_WEIGHT[2])
		      + cct_pkg::LOAD_W'(minute_units) * cct_pkg::LOAD_W'(cct_pkg::DIGIT_WEIGHT[3])
		      + cct_pkg::LOAD_W'(second_tens)  * cct_pkg::LOAD_W'(cct_pkg::DIGIT_WEIGHT[4])
		      + cct_pkg::LOAD_W'(second_units);
		load_count = (total > cct_pkg::LOAD_W'(cct_pkg::LOAD_MAX)) ?
		             cct_pkg::LOAD_MAX : total[cct_pkg::COUNT_W-1:0];
		up_count   = (count_q >= cct_pkg::DAY_LAST) ? '0 : count_q + 1'b1;
		down_count = (count_q == '0) ? '0 : count_q - 1'b1;

		tick_n  = tick_q;
		count_n = count_q;
		done_n  = done_q;
		passed  = 1'b0;
		priority if (kind == cct_pkg::KIND_LOAD) begin
			count_n = load_count;
			done_n  = 1'b0;
		end else if (sec_event) begin
			tick_n = '0;
			passed = 1'b1;
			if (mode_q == cct_pkg::MODE_CLOCK) begin
				count_n = up_count;
				done_n  = 1'b0;
			end else begin
				count_n = down_count;
				done_n  = (down_count == '0) ? 1'b1 : done_q;
			end
		end else begin
			tick_n = tick_inc[cct_pkg::TICK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q    <= cct_pkg::TICKS_RESET;
			mode_q   <= cct_pkg::MODE_CLOCK;
			tick_q   <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					cct_pkg::CFG_TICKS_PER_SECOND: tps_q  <= cfg_data;
					cct_pkg::CFG_COUNT_MODE:       mode_q <= cfg_data[0];
					default:                       tps_q  <= tps_q;
				endcase
			end
			if (accept) begin
				tick_q  <= tick_n;
				count_q <= count_n;
				done_q  <= done_n;
			end
			if (up_ready) begin
				valid_s1 <= up_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.rem    <= count_n;
			beat_s1.digits <= '0;
			beat_s1.passed <= passed;
			beat_s1.done   <= done_n;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_beat  = beat_s1;

	`CCT_ASSERT_IMPL(a_count_range, 1'b1, count_q <= cct_pkg::LOAD_MAX)
	`CCT_ASSERT_IMPL(a_done_at_zero, done_q, count_q == '0)
	`CCT_ASSERT_NEXT(a_load_keeps_prescaler, accept && kind == cct_pkg::KIND_LOAD, tick_q == $past(tick_q) && !done_q)

endmodule

// ===== src/clock_and_countdown_timer_core.sv =====
// Time-of-day clock and countdown timer core.
// Item channel: item_valid/item_stall with kind and six load digits. A tick
// beat (kind 0) advances the prescaler; a load beat (kind 1) sets the count
// from HH:MM:SS digits, saturating at 99:59:59.
// Result channel: result_valid/result_stall; every item beat yields exactly
// one result beat with the count as six digits, second_passed and finished.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index 0 sets
// ticks_per_second, 1 sets count_mode; write only while the core is idle.
// Throughput is one beat per cycle while result_stall is low. The pipeline is
// one stage that updates the count, then a row of six digit cells, each peeling one digit
// off the count by compare and subtract against its place weight.
// Reset sets ticks_per_second to 125, clock mode, count and prescaler to
// zero, and empties the pipeline.
// When the receiver stalls, each stage holds its beat and empty stages
// keep filling; item_stall rises once all seven stages hold a beat.
`include "clock_and_countdown_timer_core_macros.svh"

module clock_and_countdown_timer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [3:0]  hour_tens,
	input  logic [3:0]  hour_units,
	input  logic [3:0]  minute_tens,
	input  logic [3:0]  minute_units,
	input  logic [3:0]  second_tens,
	input  logic [3:0]  second_units,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  out_hour_tens,
	output logic [3:0]  out_hour_units,
	output logic [2:0]  out_minute_tens,
	output logic [3:0]  out_minute_units,
	output logic [2:0]  out_second_tens,
	output logic [3:0]  out_second_units,
	output logic        second_passed,
	output logic        finished
);

	logic            chain_valid [cct_pkg::NUM_DIGITS+1];
	logic            chain_ready [cct_pkg::NUM_DIGITS+1];
	cct_pkg::beat_t  chain_beat  [cct_pkg::NUM_DIGITS+1];
	logic            item_ready;
	cct_pkg::beat_t  last_beat;

	assign cfg_ready  = 1'b1;
	assign item_stall = !item_ready;

	cct_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.up_valid     (item_valid),
		.up_ready     (item_ready),
		.kind         (kind),
		.hour_tens    (hour_tens),
		.hour_units   (hour_units),
		.minute_tens  (minute_tens),
		.minute_units (minute_units),
		.second_tens  (second_tens),
		.second_units (second_units),
		.dn_valid     (chain_valid[0]),
		.dn_ready     (chain_ready[0]),
		.dn_beat      (chain_beat[0])
	);

	for (genvar g = 0; g < cct_pkg::NUM_DIGITS; g++) begin : g_cell
		cct_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.weight   (cct_pkg::DIGIT_WEIGHT[g]),
			.up_valid (chain_valid[g]),
			.up_ready (chain_ready[g]),
			.up_beat  (chain_beat[g]),
			.dn_valid (chain_valid[g+1]),
			.dn_ready (chain_ready[g+1]),
			.dn_beat  (chain_beat[g+1])
		);
	end

	assign chain_ready[cct_pkg::NUM_DIGITS] = !result_stall;
	assign last_beat    = chain_beat[cct_pkg::NUM_DIGITS];
	assign result_valid = chain_valid[cct_pkg::NUM_DIGITS];

	assign out_hour_tens    = last_beat.digits[5];
	assign out_hour_units   = last_beat.digits[4];
	assign out_minute_tens  = last_beat.digits[3][2:0];
	assign out_minute_units = last_beat.digits[2];
	assign out_second_tens  = last_beat.digits[1][2:0];
	assign out_second_units = last_beat.digits[0];
	assign second_passed    = last_beat.passed;
	assign finished         = last_beat.done;

	`CCT_ASSERT_IMPL(a_digit_range, result_valid, last_beat.rem == '0 && last_beat.digits[0] <= 4'd9 && last_beat.digits[1] <= 4'd5 && last_beat.digits[3] <= 4'd5)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic       kind;
		logic [3:0] hour_tens;
		logic [3:0] hour_units;
		logic [3:0] minute_tens;
		logic [3:0] minute_units;
		logic [3:0] second_tens;
		logic [3:0] second_units;
	} timer_item_t;

	typedef struct packed {
		logic [3:0] hour_tens;
		logic [3:0] hour_units;
		logic [2:0] minute_tens;
		logic [3:0] minute_units;
		logic [2:0] second_tens;
		logic [3:0] second_units;
		logic       passed;
		logic       done;
	} timer_view_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

	// Digits are written as hex nibbles HHMMSS for both the load and the typed expectation.
	typedef struct packed {
		row_op_t     op;
		logic        kind;
		logic [23:0] digits;
		logic        cfg_idx;
		logic [7:0]  cfg_data;
		logic        typed;
		logic [23:0] want_digits;
		logic        want_passed;
		logic        want_done;
	} step_row_t;

	localparam logic TICK     = cct_pkg::KIND_TICK;
	localparam logic LOAD     = cct_pkg::KIND_LOAD;
	localparam logic RATE_REG = cct_pkg::CFG_TICKS_PER_SECOND;
	localparam logic MODE_REG = cct_pkg::CFG_COUNT_MODE;

	localparam int NUM_ROWS = 30;
	localparam logic [7:0] DATA_COUNTDOWN = {7'd0, cct_pkg::MODE_COUNTDOWN};

	localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b0, 1'b0},
		'{ROW_ITEM, LOAD, 24'h995959, 1'b0, 8'd0, 1'b1, 24'h995959, 1'b0, 1'b0},
		'{ROW_ITEM, LOAD, 24'hFFFFFF, 1'b0, 8'd0, 1'b1, 24'h995959, 1'b0, 1'b0},
		'{ROW_ITEM, LOAD, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b0, 1'b0},
		'{ROW_CFG, TICK, 24'h0, RATE_REG, 8'd1, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, LOAD, 24'h235958, 1'b0, 8'd0, 1'b1, 24'h235958, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'hFFFFFF, 1'b0, 8'd0, 1'b1, 24'h235959, 1'b1, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b1, 1'b0},
		'{ROW_ITEM, LOAD, 24'h300000, 1'b0, 8'd0, 1'b1, 24'h300000, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b1, 1'b0},
		'{ROW_CFG, TICK, 24'h0, MODE_REG, DATA_COUNTDOWN, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, LOAD, 24'h000002, 1'b0, 8'd0, 1'b1, 24'h000002, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000001, 1'b1, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b1, 1'b1},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b1, 1'b1},
		'{ROW_ITEM, LOAD, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h000000, 1'b1, 1'b1},
		'{ROW_CFG, TICK, 24'h0, RATE_REG, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, LOAD, 24'h010000, 1'b0, 8'd0, 1'b1, 24'h010000, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b1, 24'h005959, 1'b1, 1'b0},
		'{ROW_CFG, TICK, 24'h0, RATE_REG, 8'd255, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h123456, 1'b0, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'hA5A5A5, 1'b0, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h5A5A5A, 1'b0, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_CFG, TICK, 24'h0, RATE_REG, 8'd2, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_CFG, TICK, 24'h0, MODE_REG, 8'hFE, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, TICK, 24'h000000, 1'b0, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0},
		'{ROW_ITEM, LOAD, 24'h9F3C7A, 1'b0, 8'd0, 1'b0, 24'h0, 1'b0, 1'b0}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       item_valid;
	logic       item_stall;
	logic       kind;
	logic [3:0] hour_tens;
	logic [3:0] hour_units;
	logic [3:0] minute_tens;
	logic [3:0] minute_units;
	logic [3:0] second_tens;
	logic [3:0] second_units;
	logic       result_valid;
	logic       result_stall;
	logic [3:0] out_hour_tens;
	logic [3:0] out_hour_units;
	logic [2:0] out_minute_tens;
	logic [3:0] out_minute_units;
	logic [2:0] out_second_tens;
	logic [3:0] out_second_units;
	logic       second_passed;
	logic       finished;

	clock_and_countdown_timer_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.kind             (kind),
		.hour_tens        (hour_tens),
		.hour_units       (hour_units),
		.minute_tens      (minute_tens),
		.minute_units     (minute_units),
		.second_tens      (second_tens),
		.second_units     (second_units),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.out_hour_tens    (out_hour_tens),
		.out_hour_units   (out_hour_units),
		.out_minute_tens  (out_minute_tens),
		.out_minute_units (out_minute_units),
		.out_second_tens  (out_second_tens),
		.out_second_units (out_second_units),
		.second_passed    (second_passed),
		.finished         (finished)
	);

	logic [cct_pkg::TICK_W-1:0]  rate_cfg;
	logic                        mode_cfg;
	logic [cct_pkg::TICK_W-1:0]  tick_cnt;
	logic [cct_pkg::COUNT_W-1:0] count_secs;
	logic                        done_bit;

	timer_view_t pending_views [$];
	int          fail_count;
	int          out_hold_max;
	bit          long_hold_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic timer_view_t step_timer(timer_item_t it);
		logic [cct_pkg::TICK_W:0] next_tick;
		int              total;
		int              hours;
		int              minutes;
		int              secs;
		logic            passed;
		timer_view_t     v;
		passed = 1'b0;
		if (it.kind == cct_pkg::KIND_LOAD) begin
			total = int'(it.hour_tens) * 36000 + int'(it.hour_units) * 3600
				+ int'(it.minute_tens) * 600 + int'(it.minute_units) * 60
				+ int'(it.second_tens) * 10 + int'(it.second_units);
			if (total > int'(cct_pkg::LOAD_MAX)) begin
				total = int'(cct_pkg::LOAD_MAX);
			end
			count_secs = total[cct_pkg::COUNT_W-1:0];
			done_bit = 1'b0;
		end else begin
			next_tick = {1'b0, tick_cnt} + 1'b1;
			if (next_tick >= {1'b0, rate_cfg}) begin
				tick_cnt = '0;
				passed = 1'b1;
				if (mode_cfg == cct_pkg::MODE_CLOCK) begin
					if (count_secs >= cct_pkg::DAY_LAST) begin
						count_secs = '0;
					end else begin
						count_secs = count_secs + 1'b1;
					end
					done_bit = 1'b0;
				end else begin
					if (count_secs != '0) begin
						count_secs = count_secs - 1'b1;
					end
					if (count_secs == '0) begin
						done_bit = 1'b1;
					end
				end
			end else begin
				tick_cnt = next_tick[cct_pkg::TICK_W-1:0];
			end
		end
		hours = int'(count_secs) / 3600;
		minutes = (int'(count_secs) / 60) % 60;
		secs = int'(count_secs) % 60;
		v.hour_tens = 4'((hours / 10) % 10);
		v.hour_units = 4'(hours % 10);
		v.minute_tens = 3'(minutes / 10);
		v.minute_units = 4'(minutes % 10);
		v.second_tens = 3'(secs / 10);
		v.second_units = 4'(secs % 10);
		v.passed = passed;
		v.done = done_bit;
		return v;
	endfunction

	function automatic timer_view_t view_from_row(step_row_t row);
		timer_view_t v;
		v.hour_tens = row.want_digits[23:20];
		v.hour_units = row.want_digits[19:16];
		v.minute_tens = row.want_digits[14:12];
		v.minute_units = row.want_digits[11:8];
		v.second_tens = row.want_digits[6:4];
		v.second_units = row.want_digits[3:0];
		v.passed = row.want_passed;
		v.done = row.want_done;
		return v;
	endfunction

	function automatic timer_item_t random_item(int load_pct);
		timer_item_t it;
		it = timer_item_t'(25'($urandom));
		it.kind = ($urandom_range(0, 99) < load_pct) ? cct_pkg::KIND_LOAD : cct_pkg::KIND_TICK;
		if (it.kind == cct_pkg::KIND_LOAD) begin
			case ($urandom_range(0, 3))
				0: begin
					it.hour_tens = 4'($urandom_range(0, 9));
					it.hour_units = 4'($urandom_range(0, 9));
					it.minute_tens = 4'($urandom_range(0, 5));
					it.minute_units = 4'($urandom_range(0, 9));
					it.second_tens = 4'($urandom_range(0, 5));
					it.second_units = 4'($urandom_range(0, 9));
				end
				1: begin
					{it.hour_tens, it.hour_units} = 8'h23;
					{it.minute_tens, it.minute_units} = 8'h59;
					it.second_tens = 4'd5;
					it.second_units = 4'($urandom_range(0, 9));
				end
				2: begin
					{it.hour_tens, it.hour_units, it.minute_tens, it.minute_units} = '0;
					it.second_tens = 4'($urandom_range(0, 1));
					it.second_units = 4'($urandom_range(0, 9));
				end
				default: begin
				end
			endcase
		end
		return it;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		timer_view_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_views.size() == 0) begin
				$error("result beat with no expectation waiting");
				fail_count++;
			end else begin
				want = pending_views.pop_front();
				check_field("out_hour_tens", want.hour_tens, out_hour_tens);
				check_field("out_hour_units", want.hour_units, out_hour_units);
				check_field("out_minute_tens", want.minute_tens, out_minute_tens);
				check_field("out_minute_units", want.minute_units, out_minute_units);
				check_field("out_second_tens", want.second_tens, out_second_tens);
				check_field("out_second_units", want.second_units, out_second_units);
				check_field("second_passed", want.passed, second_passed);
				check_field("finished", want.done, finished);
			end
		end
	end

	initial begin
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, out_hold_max);
			if (long_hold_req) begin
				hold = 250;
				long_hold_req = 1'b0;
			end
			if (hold > 0) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
				@(negedge clk);
				result_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(result_valid && !result_stall)) @(posedge clk);
		end
	end

	task automatic send_item(timer_item_t it, int gap, bit typed, timer_view_t typed_view);
		timer_view_t predicted;
		@(negedge clk);
		item_valid <= 1'b1;
		kind <= it.kind;
		hour_tens <= it.hour_tens;
		hour_units <= it.hour_units;
		minute_tens <= it.minute_tens;
		minute_units <= it.minute_units;
		second_tens <= it.second_tens;
		second_units <= it.second_units;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predicted = step_timer(it);
		pending_views.push_back(typed ? typed_view : predicted);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == cct_pkg::CFG_TICKS_PER_SECOND) begin
			rate_cfg = data;
		end else begin
			mode_cfg = data[0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int n, int load_pct, int gap_max, int hold_max);
		out_hold_max = hold_max;
		for (int i = 0; i < n; i++) begin
			send_item(random_item(load_pct), $urandom_range(0, gap_max), 1'b0, '0);
		end
		drain_results();
	endtask

	initial begin
		step_row_t row;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		item_valid = 1'b0;
		kind = cct_pkg::KIND_TICK;
		hour_tens = '0;
		hour_units = '0;
		minute_tens = '0;
		minute_units = '0;
		second_tens = '0;
		second_units = '0;
		fail_count = 0;
		out_hold_max = 12;
		long_hold_req = 1'b0;
		rate_cfg = cct_pkg::TICKS_RESET;
		mode_cfg = cct_pkg::MODE_CLOCK;
		tick_cnt = '0;
		count_secs = '0;
		done_bit = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.op == ROW_CFG) begin
				drain_results();
				write_reg(row.cfg_idx, row.cfg_data);
			end else begin
				send_item(timer_item_t'({row.kind, row.digits}), $urandom_range(0, 12),
					row.typed, view_from_row(row));
			end
		end
		drain_results();

		write_reg(cct_pkg::CFG_TICKS_PER_SECOND, 8'd1);
		write_reg(cct_pkg::CFG_COUNT_MODE, {7'($urandom_range(0, 127)), cct_pkg::MODE_CLOCK});
		run_random(220, 10, 12, 12);

		write_reg(cct_pkg::CFG_TICKS_PER_SECOND, 8'd255);
		run_random(300, 2, 0, 0);

		// The receiver holds off while items keep coming, so the pipeline fills.
		write_reg(cct_pkg::CFG_TICKS_PER_SECOND, 8'd0);
		write_reg(cct_pkg::CFG_COUNT_MODE, DATA_COUNTDOWN);
		long_hold_req = 1'b1;
		run_random(200, 15, 0, 12);

		write_reg(cct_pkg::CFG_TICKS_PER_SECOND, 8'($urandom_range(2, 9)));
		run_random(250, 20, 12, 12);

		write_reg(cct_pkg::CFG_TICKS_PER_SECOND, 8'd3);
		write_reg(cct_pkg::CFG_COUNT_MODE, 8'($urandom));
		run_random(200, 10, 4, 0);

		write_reg(cct_pkg::CFG_TICKS_PER_SECOND, 8'($urandom_range(1, 20)));
		write_reg(cct_pkg::CFG_COUNT_MODE, 8'($urandom));
		run_random(180, 12, 12, 12);

		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
